// ===== rtl/isb_pkg.sv =====
// ----------------------------------------------------------------------------
// isb_pkg
// Shared types and constants of the two-wire slave byte engine: event kinds,
// shifter action codes, bus phases, ring depths and the word layouts.
// ----------------------------------------------------------------------------
package isb_pkg;

  // ring depths and the widths that follow from them
  localparam int RX_DEPTH = 32;
  localparam int TX_DEPTH = 32;
  localparam int RX_PTR_W = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int TX_PTR_W = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam int RX_FILL_W = $clog2(RX_DEPTH + 1);
  localparam int TX_FILL_W = $clog2(TX_DEPTH + 1);

  // field widths
  localparam int KIND_W = 2;
  localparam int BYTE_W = 8;
  localparam int ACT_W = 3;
  localparam int LEVEL_W = 6;
  localparam int ADDR_W = 7;
  localparam int PHASE_W = 3;

  // own address after reset
  localparam logic [ADDR_W-1:0] OWN_ADDR_RESET = 7'd8;

  // read/write bit of the address byte, and the general call address
  localparam logic [BYTE_W-1:0] READ_BIT = 8'h01;
  localparam logic [BYTE_W-1:0] GENERAL_CALL = 8'h00;

  // event kinds
  localparam logic [KIND_W-1:0] KIND_START = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SHIFT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PUSH = 2'd2;
  localparam logic [KIND_W-1:0] KIND_POP = 2'd3;

  // shifter actions
  localparam logic [ACT_W-1:0] ACT_WAIT_ADDR = 3'd0;
  localparam logic [ACT_W-1:0] ACT_SEND_ACK = 3'd1;
  localparam logic [ACT_W-1:0] ACT_SEND_DATA = 3'd2;
  localparam logic [ACT_W-1:0] ACT_WAIT_ACK = 3'd3;
  localparam logic [ACT_W-1:0] ACT_RECEIVE = 3'd4;
  localparam logic [ACT_W-1:0] ACT_NONE = 3'd5;

  // bus phases
  localparam logic [PHASE_W-1:0] PH_CHECK_ADDR = 3'd0;
  localparam logic [PHASE_W-1:0] PH_SEND = 3'd1;
  localparam logic [PHASE_W-1:0] PH_WAIT_ACK = 3'd2;
  localparam logic [PHASE_W-1:0] PH_CHECK_ACK = 3'd3;
  localparam logic [PHASE_W-1:0] PH_WAIT_RX = 3'd4;
  localparam logic [PHASE_W-1:0] PH_RX = 3'd5;
  localparam logic [PHASE_W-1:0] PH_IDLE = 3'd6;

  // input word
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] bus_byte;
    logic [BYTE_W-1:0] host_byte;
  } item_t;

  // result word
  typedef struct packed {
    logic [ACT_W-1:0] next_action;
    logic [BYTE_W-1:0] drive_byte;
    logic read_start;
    logic read_done;
    logic [BYTE_W-1:0] rx_data;
    logic rx_valid;
    logic overrun;
    logic tx_rejected;
    logic [LEVEL_W-1:0] rx_level;
    logic [LEVEL_W-1:0] tx_level;
  } result_t;

endpackage

// ===== rtl/i2c_slave_byte_engine_core.sv =====
// ----------------------------------------------------------------------------
// i2c_slave_byte_engine_core
// Byte-level two-wire slave: address match, receive ring, transmit ring and
// the next action for the bit shifter, one event word per cycle while the result side keeps up.
// ----------------------------------------------------------------------------
// One event word is taken per cycle and its result word appears in the
// output register in the following cycle; the engine keeps taking words
// while a result waits, so long as the output register is free or being
// emptied in the same cycle. Throughput is one word per cycle, set by the
// single pass from the event port through the phase logic and ring pointers
// into the output register; the ring bytes come from each ring's memory read
// register, loaded in that same cycle. The own address may be written at any
// time through the config port, which is always ready.
module i2c_slave_byte_engine_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  isb_pkg::item_t                item,
  output logic                          result_valid,
  input  logic                          result_ready,
  output isb_pkg::result_t              result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [isb_pkg::ADDR_W-1:0]    cfg_data
);

  // ring memories and their registered read ports
  logic [isb_pkg::BYTE_W-1:0] rx_mem [isb_pkg::RX_DEPTH];
  logic [isb_pkg::BYTE_W-1:0] tx_mem [isb_pkg::TX_DEPTH];
  logic [isb_pkg::BYTE_W-1:0] rx_rd;
  logic [isb_pkg::BYTE_W-1:0] tx_rd;

  // control state
  logic [isb_pkg::ADDR_W-1:0]    own_address;
  logic [isb_pkg::PHASE_W-1:0]   bus_phase, bus_phase_next;
  logic [isb_pkg::RX_PTR_W-1:0]  rx_write_ptr, rx_read_ptr;
  logic [isb_pkg::TX_PTR_W-1:0]  tx_write_ptr, tx_read_ptr;
  logic [isb_pkg::RX_FILL_W-1:0] rx_fill, rx_fill_next;
  logic [isb_pkg::TX_FILL_W-1:0] tx_fill, tx_fill_next;

  // output register
  logic                        out_valid;
  logic [isb_pkg::ACT_W-1:0]   out_action;
  logic                        out_send;
  logic                        out_rstart;
  logic                        out_rdone;
  logic                        out_rvalid;
  logic                        out_ovr;
  logic                        out_rej;
  logic [isb_pkg::LEVEL_W-1:0] out_rx_level;
  logic [isb_pkg::LEVEL_W-1:0] out_tx_level;

  // event decode results
  logic                      accept;
  logic [isb_pkg::ACT_W-1:0] action;
  logic                      rstart, rdone, ovr, rej;
  logic                      do_send, send_ok;
  logic                      rx_wr, tx_wr, pop_ok;
  logic                      addr_match;

  assign item_ready = !out_valid || result_ready;
  assign accept = item_valid && item_ready;
  assign cfg_ready = 1'b1;

  assign addr_match = (item.bus_byte == isb_pkg::GENERAL_CALL) ||
                      (item.bus_byte[isb_pkg::BYTE_W-1:1] == own_address);

  // phase and ring decisions for one event word
  always_comb begin
    bus_phase_next = bus_phase;
    action = isb_pkg::ACT_NONE;
    rstart = 1'b0;
    rdone = 1'b0;
    ovr = 1'b0;
    rej = 1'b0;
    do_send = 1'b0;
    rx_wr = 1'b0;
    tx_wr = 1'b0;
    pop_ok = 1'b0;
    unique case (item.kind)
      isb_pkg::KIND_START: begin
        bus_phase_next = isb_pkg::PH_CHECK_ADDR;
        action = isb_pkg::ACT_WAIT_ADDR;
      end
      isb_pkg::KIND_SHIFT: begin
        unique case (bus_phase)
          isb_pkg::PH_CHECK_ADDR: begin
            if (addr_match) begin
              if ((item.bus_byte & isb_pkg::READ_BIT) != '0) begin
                rstart = 1'b1;
                bus_phase_next = isb_pkg::PH_SEND;
              end else begin
                bus_phase_next = isb_pkg::PH_WAIT_RX;
              end
              action = isb_pkg::ACT_SEND_ACK;
            end else begin
              bus_phase_next = isb_pkg::PH_IDLE;
              action = isb_pkg::ACT_WAIT_ADDR;
            end
          end
          isb_pkg::PH_CHECK_ACK: begin
            if (item.bus_byte != '0) begin
              rdone = 1'b1;
              bus_phase_next = isb_pkg::PH_IDLE;
              action = isb_pkg::ACT_WAIT_ADDR;
            end else begin
              do_send = 1'b1;
            end
          end
          isb_pkg::PH_SEND: begin
            do_send = 1'b1;
          end
          isb_pkg::PH_WAIT_ACK: begin
            bus_phase_next = isb_pkg::PH_CHECK_ACK;
            action = isb_pkg::ACT_WAIT_ACK;
          end
          isb_pkg::PH_WAIT_RX: begin
            bus_phase_next = isb_pkg::PH_RX;
            action = isb_pkg::ACT_RECEIVE;
          end
          isb_pkg::PH_RX: begin
            if (rx_fill < isb_pkg::RX_FILL_W'(isb_pkg::RX_DEPTH)) begin
              rx_wr = 1'b1;
            end else begin
              ovr = 1'b1;
            end
            bus_phase_next = isb_pkg::PH_WAIT_RX;
            action = isb_pkg::ACT_SEND_ACK;
          end
          default: begin
            bus_phase_next = isb_pkg::PH_IDLE;
            action = isb_pkg::ACT_NONE;
          end
        endcase
        // serve a data byte from the transmit ring
        if (do_send) begin
          if (tx_fill != '0) begin
            bus_phase_next = isb_pkg::PH_WAIT_ACK;
            action = isb_pkg::ACT_SEND_DATA;
          end else begin
            bus_phase_next = isb_pkg::PH_IDLE;
            action = isb_pkg::ACT_WAIT_ADDR;
          end
        end
      end
      isb_pkg::KIND_PUSH: begin
        if (tx_fill >= isb_pkg::TX_FILL_W'(isb_pkg::TX_DEPTH)) begin
          rej = 1'b1;
        end else begin
          tx_wr = 1'b1;
        end
      end
      isb_pkg::KIND_POP: begin
        pop_ok = (rx_fill != '0);
      end
      default: begin
        action = isb_pkg::ACT_NONE;
      end
    endcase
  end

  assign send_ok = do_send && (tx_fill != '0);

  // ring fill counts
  always_comb begin
    rx_fill_next = rx_fill;
    tx_fill_next = tx_fill;
    if (rx_wr) begin
      rx_fill_next = rx_fill + 1'b1;
    end else if (pop_ok) begin
      rx_fill_next = rx_fill - 1'b1;
    end
    if (tx_wr) begin
      tx_fill_next = tx_fill + 1'b1;
    end else if (send_ok) begin
      tx_fill_next = tx_fill - 1'b1;
    end
  end

  // own address register
  always_ff @(posedge clk) begin
    if (rst) begin
      own_address <= isb_pkg::OWN_ADDR_RESET;
    end else if (cfg_valid) begin
      own_address <= cfg_data;
    end
  end

  // phase, pointers and fill counts
  always_ff @(posedge clk) begin
    if (rst) begin
      bus_phase <= isb_pkg::PH_CHECK_ADDR;
      rx_write_ptr <= '0;
      rx_read_ptr <= '0;
      tx_write_ptr <= '0;
      tx_read_ptr <= '0;
      rx_fill <= '0;
      tx_fill <= '0;
    end else if (accept) begin
      bus_phase <= bus_phase_next;
      rx_fill <= rx_fill_next;
      tx_fill <= tx_fill_next;
      if (rx_wr) begin
        rx_write_ptr <= (rx_write_ptr == isb_pkg::RX_PTR_W'(isb_pkg::RX_DEPTH - 1)) ?
                        '0 : rx_write_ptr + 1'b1;
      end
      if (pop_ok) begin
        rx_read_ptr <= (rx_read_ptr == isb_pkg::RX_PTR_W'(isb_pkg::RX_DEPTH - 1)) ?
                       '0 : rx_read_ptr + 1'b1;
      end
      if (tx_wr) begin
        tx_write_ptr <= (tx_write_ptr == isb_pkg::TX_PTR_W'(isb_pkg::TX_DEPTH - 1)) ?
                        '0 : tx_write_ptr + 1'b1;
      end
      if (send_ok) begin
        tx_read_ptr <= (tx_read_ptr == isb_pkg::TX_PTR_W'(isb_pkg::TX_DEPTH - 1)) ?
                       '0 : tx_read_ptr + 1'b1;
      end
    end
  end

  // receive ring memory
  always_ff @(posedge clk) begin
    if (accept && rx_wr) begin
      rx_mem[rx_write_ptr] <= item.bus_byte;
    end
    if (accept) begin
      rx_rd <= rx_mem[rx_read_ptr];
    end
  end

  // transmit ring memory
  always_ff @(posedge clk) begin
    if (accept && tx_wr) begin
      tx_mem[tx_write_ptr] <= item.host_byte;
    end
    if (accept) begin
      tx_rd <= tx_mem[tx_read_ptr];
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (item_ready) begin
      out_valid <= item_valid;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_action <= action;
      out_send <= send_ok;
      out_rstart <= rstart;
      out_rdone <= rdone;
      out_rvalid <= pop_ok;
      out_ovr <= ovr;
      out_rej <= rej;
      out_rx_level <= isb_pkg::LEVEL_W'(rx_fill_next);
      out_tx_level <= isb_pkg::LEVEL_W'(tx_fill_next);
    end
  end

  // result word
  assign result_valid = out_valid;
  always_comb begin
    result.next_action = out_action;
    result.drive_byte = out_send ? tx_rd : '0;
    result.read_start = out_rstart;
    result.read_done = out_rdone;
    result.rx_data = out_rvalid ? rx_rd : '0;
    result.rx_valid = out_rvalid;
    result.overrun = out_ovr;
    result.tx_rejected = out_rej;
    result.rx_level = out_rx_level;
    result.tx_level = out_tx_level;
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-wire slave byte engine. Bus and host event
// words are fed through the valid/ready port and a cycle-level model of the
// address match, receive ring and transmit ring predicts every result word.
// A directed opening covers the corner cases. Random master reads, master
// writes, ring bursts and noise follow under several own addresses, with
// random stalls on both sides and one long hold-off on the result side.
// ----------------------------------------------------------------------------
module tb;
  import isb_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int SQUEEZE_CYCLES = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  item_t item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ADDR_W-1:0] cfg_data = '0;

  // words waiting to be sent, and results the engine still owes
  item_t pending_events[$];
  result_t owed_results[$];
  result_t want_res;
  logic item_fire = 1'b0;
  int bad_results = 0;

  // stimulus control
  logic calm = 1'b0;
  logic squeeze_req = 1'b0;
  logic squeeze_done = 1'b0;
  int hold_left = 0;
  logic [ADDR_W-1:0] own_setting = OWN_ADDR_RESET;

  // model state
  logic [ADDR_W-1:0] own_addr;
  logic [PHASE_W-1:0] bus_ph;
  logic [BYTE_W-1:0] rx_ring [RX_DEPTH];
  logic [BYTE_W-1:0] tx_ring [TX_DEPTH];
  logic [RX_PTR_W-1:0] rx_head, rx_tail;
  logic [TX_PTR_W-1:0] tx_head, tx_tail;
  logic [RX_FILL_W-1:0] rx_count;
  logic [TX_FILL_W-1:0] tx_count;

  i2c_slave_byte_engine_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // next state and result word of the engine for one event word
  function automatic result_t engine_next(item_t w);
    result_t r;
    logic send_now;
    r = '0;
    r.next_action = ACT_NONE;
    send_now = 1'b0;
    case (w.kind)
      KIND_START: begin
        bus_ph = PH_CHECK_ADDR;
        r.next_action = ACT_WAIT_ADDR;
      end
      KIND_SHIFT: begin
        case (bus_ph)
          PH_CHECK_ADDR: begin
            if (w.bus_byte == GENERAL_CALL || w.bus_byte[BYTE_W-1:1] == own_addr) begin
              if ((w.bus_byte & READ_BIT) != '0) begin
                r.read_start = 1'b1;
                bus_ph = PH_SEND;
              end else begin
                bus_ph = PH_WAIT_RX;
              end
              r.next_action = ACT_SEND_ACK;
            end else begin
              bus_ph = PH_IDLE;
              r.next_action = ACT_WAIT_ADDR;
            end
          end
          PH_CHECK_ACK: begin
            if (w.bus_byte != '0) begin
              r.read_done = 1'b1;
              bus_ph = PH_IDLE;
              r.next_action = ACT_WAIT_ADDR;
            end else begin
              send_now = 1'b1;
            end
          end
          PH_SEND: send_now = 1'b1;
          PH_WAIT_ACK: begin
            bus_ph = PH_CHECK_ACK;
            r.next_action = ACT_WAIT_ACK;
          end
          PH_WAIT_RX: begin
            bus_ph = PH_RX;
            r.next_action = ACT_RECEIVE;
          end
          PH_RX: begin
            // a full ring drops the byte but still acknowledges it
            if (rx_count < RX_DEPTH) begin
              rx_ring[rx_head] = w.bus_byte;
              rx_head = (rx_head == RX_DEPTH - 1) ? '0 : rx_head + 1'b1;
              rx_count = rx_count + 1'b1;
            end else begin
              r.overrun = 1'b1;
            end
            bus_ph = PH_WAIT_RX;
            r.next_action = ACT_SEND_ACK;
          end
          default: begin
            bus_ph = PH_IDLE;
            r.next_action = ACT_NONE;
          end
        endcase
        // serve the next transmit byte, or give up the bus when none is left
        if (send_now) begin
          if (tx_count != '0) begin
            r.drive_byte = tx_ring[tx_tail];
            tx_tail = (tx_tail == TX_DEPTH - 1) ? '0 : tx_tail + 1'b1;
            tx_count = tx_count - 1'b1;
            bus_ph = PH_WAIT_ACK;
            r.next_action = ACT_SEND_DATA;
          end else begin
            bus_ph = PH_IDLE;
            r.next_action = ACT_WAIT_ADDR;
          end
        end
      end
      KIND_PUSH: begin
        if (tx_count >= TX_DEPTH) begin
          r.tx_rejected = 1'b1;
        end else begin
          tx_ring[tx_head] = w.host_byte;
          tx_head = (tx_head == TX_DEPTH - 1) ? '0 : tx_head + 1'b1;
          tx_count = tx_count + 1'b1;
        end
      end
      KIND_POP: begin
        if (rx_count != '0) begin
          r.rx_data = rx_ring[rx_tail];
          r.rx_valid = 1'b1;
          rx_tail = (rx_tail == RX_DEPTH - 1) ? '0 : rx_tail + 1'b1;
          rx_count = rx_count - 1'b1;
        end
      end
      default: ;
    endcase
    r.rx_level = rx_count;
    r.tx_level = tx_count;
    return r;
  endfunction

  function automatic string show(result_t r);
    return $sformatf("act %0d drive %02h rs %0b rd %0b data %02h dv %0b ovr %0b rej %0b rx %0d tx %0d",
                     r.next_action, r.drive_byte, r.read_start, r.read_done, r.rx_data,
                     r.rx_valid, r.overrun, r.tx_rejected, r.rx_level, r.tx_level);
  endfunction

  // word builders
  function automatic logic [BYTE_W-1:0] rnd_byte();
    return BYTE_W'($urandom_range(255));
  endfunction

  function automatic void queue_word(logic [KIND_W-1:0] k, logic [BYTE_W-1:0] b,
                                     logic [BYTE_W-1:0] h);
    item_t w;
    w.kind = k;
    w.bus_byte = b;
    w.host_byte = h;
    pending_events.push_back(w);
  endfunction

  function automatic void put_start();
    queue_word(KIND_START, rnd_byte(), rnd_byte());
  endfunction

  function automatic void put_shift(logic [BYTE_W-1:0] b);
    queue_word(KIND_SHIFT, b, rnd_byte());
  endfunction

  function automatic void put_push(logic [BYTE_W-1:0] h);
    queue_word(KIND_PUSH, rnd_byte(), h);
  endfunction

  function automatic void put_pop();
    queue_word(KIND_POP, rnd_byte(), rnd_byte());
  endfunction

  // host side activity between bus events
  function automatic void host_traffic(int push_pct, int pop_pct);
    if ($urandom_range(99) < push_pct)
      put_push(rnd_byte());
    if ($urandom_range(99) < pop_pct)
      put_pop();
  endfunction

  // one random stretch of bus and host traffic
  function automatic void add_traffic(int push_pct, int pop_pct);
    int pick, n;
    logic [BYTE_W-1:0] addr;
    pick = $urandom_range(99);
    if (pick < 38) begin
      // master write, sometimes long enough to overrun the receive ring
      n = ($urandom_range(9) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 6);
      addr = ($urandom_range(6) == 0) ? GENERAL_CALL : {own_setting, 1'b0};
      put_start();
      put_shift(addr);
      for (int i = 0; i < n; i++) begin
        put_shift(rnd_byte());
        host_traffic(push_pct, pop_pct);
        put_shift(rnd_byte());
      end
    end else if (pick < 72) begin
      // master read, acked until the last byte
      n = $urandom_range(1, 6);
      put_start();
      put_shift({own_setting, 1'b1});
      put_shift(rnd_byte());
      for (int i = 0; i < n; i++) begin
        put_shift(rnd_byte());
        host_traffic(push_pct, pop_pct);
        put_shift((i == n - 1) ? BYTE_W'($urandom_range(1, 255)) : '0);
      end
    end else if (pick < 80) begin
      // host burst that fills or empties a ring
      n = $urandom_range(TX_DEPTH, TX_DEPTH + 3);
      if ($urandom_range(1) == 0) begin
        for (int i = 0; i < n; i++)
          put_push(rnd_byte());
      end else begin
        for (int i = 0; i < n; i++)
          put_pop();
      end
    end else if (pick < 90) begin
      // stray address and loose shifts
      put_start();
      put_shift(rnd_byte());
      n = $urandom_range(3);
      for (int i = 0; i < n; i++)
        put_shift(rnd_byte());
    end else begin
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++)
        queue_word(KIND_W'($urandom_range(3)), rnd_byte(), rnd_byte());
    end
  endfunction

  function automatic void fill_phase(int n, int push_pct, int pop_pct);
    int target;
    target = pending_events.size() + n;
    while (pending_events.size() < target)
      add_traffic(push_pct, pop_pct);
  endfunction

  // engine idle: nothing queued, nothing offered, nothing owed
  task automatic wait_drained();
    while (pending_events.size() != 0 || item_valid || owed_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_own_address(logic [ADDR_W-1:0] v);
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    own_setting = v;
  endtask

  // event word driver
  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || item_fire) begin
      if (pending_events.size() != 0 && (calm || $urandom_range(99) >= 10)) begin
        item <= pending_events.pop_front();
        item_valid <= 1'b1;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // result side: random stalls and one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (squeeze_req && !squeeze_done) begin
        hold_left = SQUEEZE_CYCLES;
        squeeze_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= calm || ($urandom_range(99) >= 10);
      end
    end
  end

  // monitor: check result words, track config, predict from accepted words
  always @(posedge clk) begin
    if (rst) begin
      item_fire <= 1'b0;
      own_addr = OWN_ADDR_RESET;
      bus_ph = PH_CHECK_ADDR;
      rx_head = '0;
      rx_tail = '0;
      rx_count = '0;
      tx_head = '0;
      tx_tail = '0;
      tx_count = '0;
    end else begin
      item_fire <= item_valid && item_ready;
      if (result_valid && result_ready) begin
        if (owed_results.size() == 0) begin
          bad_results++;
          if (bad_results <= 10)
            $display("%0t: result with nothing owed: %s", $time, show(result));
        end else begin
          want_res = owed_results.pop_front();
          if (want_res.next_action !== result.next_action ||
              want_res.drive_byte !== result.drive_byte ||
              want_res.read_start !== result.read_start ||
              want_res.read_done !== result.read_done ||
              want_res.rx_data !== result.rx_data ||
              want_res.rx_valid !== result.rx_valid ||
              want_res.overrun !== result.overrun ||
              want_res.tx_rejected !== result.tx_rejected ||
              want_res.rx_level !== result.rx_level ||
              want_res.tx_level !== result.tx_level) begin
            bad_results++;
            if (bad_results <= 10) begin
              $display("%0t: mismatch", $time);
              $display("  expected %s", show(want_res));
              $display("  actual   %s", show(result));
            end
          end
        end
      end
      if (cfg_valid && cfg_ready)
        own_addr = cfg_data;
      if (item_valid && item_ready)
        owed_results.push_back(engine_next(item));
    end
  end

  // watchdog on cycles with no word moving anywhere
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (item_valid && item_ready) || (result_valid && result_ready) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb failed");
    $finish;
  end

  // stimulus sequence
  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // opening corner cases at the reset address
    put_pop();
    put_shift(8'hFF);
    put_shift({own_setting, 1'b0});
    put_start();
    put_shift({own_setting, 1'b0});
    put_shift(8'hFF);
    put_shift(8'hFF);
    put_shift(8'h00);
    put_shift(8'h00);
    put_pop();
    put_start();
    put_shift({own_setting, 1'b1});
    put_shift(8'h00);
    put_push(8'h00);
    put_push(8'hFF);
    put_start();
    put_shift(GENERAL_CALL);
    put_start();
    put_shift({own_setting, 1'b1});
    put_shift(8'hFF);
    put_shift(8'h00);
    put_shift(8'h00);
    put_shift(8'h00);
    put_shift(8'h01);
    put_pop();

    // lowest address: the read bit alone selects this slave
    write_own_address('0);
    put_start();
    put_shift(READ_BIT);
    put_push(8'hA5);
    put_shift(rnd_byte());
    put_shift(rnd_byte());
    put_shift(8'h80);
    fill_phase(180, 30, 30);

    // highest address, transmit-heavy, with the result side held off
    write_own_address('1);
    fill_phase(300, 45, 10);
    squeeze_req = 1'b1;

    // back-to-back stretch with no stalls on either side
    write_own_address(ADDR_W'($urandom_range(1, 126)));
    calm = 1'b1;
    fill_phase(250, 25, 25);

    write_own_address(ADDR_W'($urandom_range(1, 126)));
    calm = 1'b0;
    fill_phase(300, 20, 35);

    wait_drained();
    repeat (8) @(posedge clk);
    if (bad_results == 0 && owed_results.size() == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule

// ===== i2c_slave_byte_engine_core.f =====
rtl/isb_pkg.sv
rtl/i2c_slave_byte_engine_core.sv
tb/tb.sv
